// ===== design/bwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_pkg: shared types and constants of the breakpoint/watchpoint table
// Table sizes, operation and status codes, and the transaction structs.
// ----------------------------------------------------------------------------
package bwt_pkg;

   localparam int BREAK_ENTRIES = 16;
   localparam int WATCH_ENTRIES = 4;
   localparam int BCNT_W        = $clog2(BREAK_ENTRIES + 1);
   localparam int WCNT_W        = $clog2(WATCH_ENTRIES + 1);

   typedef enum logic [2:0] {
      KIND_BP_INSERT = 3'd0,
      KIND_BP_REMOVE = 3'd1,
      KIND_WP_INSERT = 3'd2,
      KIND_WP_REMOVE = 3'd3,
      KIND_CHECK_PC  = 3'd4
   } kind_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] address;
      logic [1:0]  watch_type;
      logic [3:0]  watch_size;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       hit;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  wtype;
      logic [31:0] address;
      logic [3:0]  size;
   } watch_entry_type;

   // Per-cell control: ins and rem are the operation strobes for this cycle,
   // occ marks that the cell holds a live entry.
   typedef struct packed {
      logic ins;
      logic rem;
      logic occ;
   } cell_ctl_type;

endpackage

// ===== design/bwt_break_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_break_cell: one slot of the sorted breakpoint chain
// Holds one address, compares it with the key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module bwt_break_cell (
   input  logic                  clock,
   input  bwt_pkg::cell_ctl_type ctl,
   input  logic [31:0]           key,
   input  logic [31:0]           prev_addr,
   input  logic [31:0]           next_addr,
   input  logic                  prev_ge,
   input  logic                  prev_seen,
   output logic [31:0]           addr,
   output logic                  ge,
   output logic                  seen,
   output logic                  match
);
   import bwt_pkg::*;

   logic [31:0] addr_ff;
   logic [31:0] addr_in;

   assign addr  = addr_ff;
   // Free slots count as "not smaller", so the sorted run ends at the count.
   assign ge    = !(ctl.occ && (addr_ff < key));
   assign match = ctl.occ && (addr_ff == key);
   assign seen  = prev_seen || match;

   always_comb begin
      addr_in = addr_ff;
      if (ctl.ins) begin
         if (ge && !prev_ge) begin
            addr_in = key;
         end else if (ge) begin
            addr_in = prev_addr;
         end
      end else if (ctl.rem && seen) begin
         addr_in = next_addr;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

endmodule

// ===== design/bwt_watch_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_watch_cell: one slot of the compact watchpoint chain
// Holds type, address and size; loads on append and shifts down on removal.
// ----------------------------------------------------------------------------
module bwt_watch_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  bwt_pkg::cell_ctl_type    ctl,
   input  bwt_pkg::watch_entry_type key,
   input  bwt_pkg::watch_entry_type next_entry,
   input  logic                     prev_seen,
   output bwt_pkg::watch_entry_type entry,
   output logic                     seen
);
   import bwt_pkg::*;

   watch_entry_type entry_ff;
   watch_entry_type entry_in;
   logic            match;

   assign entry = entry_ff;
   assign match = ctl.occ && (entry_ff == key);
   assign seen  = prev_seen || match;

   // Here ctl.ins marks this cell as the append slot.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         entry_in = key;
      end else if (ctl.rem && seen) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== design/breakpoint_watchpoint_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_table: debug breakpoint and watchpoint comparator
// A sorted chain of breakpoint cells and a compact chain of watchpoint cells.
// ----------------------------------------------------------------------------
// The response appears on rsp_strobe in the cycle after start is taken.
// Throughput: one transaction per cycle; every cell compares and shifts in the
// same cycle, so busy never rises.
// Reset clears both entry counts and the watchpoint cells; breakpoint
// addresses are not cleared and only occupied cells are ever compared.
// Responses cannot be stalled by the receiver.
module breakpoint_watchpoint_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bwt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bwt_pkg::rsp_type rsp_data
);
   import bwt_pkg::*;

   logic accept;

   logic [BCNT_W-1:0] bcount_ff, bcount_in;
   logic [WCNT_W-1:0] wcount_ff, wcount_in;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff, rsp_in;

   logic is_bp_ins, is_bp_rem, is_wp_ins, is_wp_rem, is_check;
   logic bp_full, wp_full, bp_found, wp_found, bp_hit;

   // Neighbor links of the breakpoint chain; index i feeds cell i+1.
   logic [31:0] b_addr  [BREAK_ENTRIES];
   logic        b_ge    [BREAK_ENTRIES];
   logic        b_seen  [BREAK_ENTRIES];
   logic        b_match [BREAK_ENTRIES];
   logic [BREAK_ENTRIES-1:0] b_match_vec;

   watch_entry_type w_entry [WATCH_ENTRIES];
   logic            w_seen  [WATCH_ENTRIES];
   watch_entry_type w_key;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_bp_ins = accept && (req_data.kind == KIND_BP_INSERT);
   assign is_bp_rem = accept && (req_data.kind == KIND_BP_REMOVE);
   assign is_wp_ins = accept && (req_data.kind == KIND_WP_INSERT);
   assign is_wp_rem = accept && (req_data.kind == KIND_WP_REMOVE);
   assign is_check  = accept && (req_data.kind == KIND_CHECK_PC);

   assign bp_full = (bcount_ff == BCNT_W'(BREAK_ENTRIES));
   assign wp_full = (wcount_ff == WCNT_W'(WATCH_ENTRIES));

   assign w_key.wtype   = req_data.watch_type;
   assign w_key.address = req_data.address;
   assign w_key.size    = req_data.watch_size;

   // Breakpoint chain. An insert drops the key in front of the first entry
   // that is not smaller and every later cell takes its lower neighbor. A
   // removal shifts every cell from the first match onward down by one.
   for (genvar i = 0; i < BREAK_ENTRIES; i++) begin : g_break
      cell_ctl_type ctl;
      logic [31:0]  prev_addr, next_addr;
      logic         prev_ge, prev_seen;

      assign ctl.ins = is_bp_ins && !bp_full;
      assign ctl.rem = is_bp_rem;
      assign ctl.occ = (BCNT_W'(i) < bcount_ff);

      if (i == 0) begin : g_first
         assign prev_addr = '0;
         assign prev_ge   = 1'b0;
         assign prev_seen = 1'b0;
      end else begin : g_inner
         assign prev_addr = b_addr[i-1];
         assign prev_ge   = b_ge[i-1];
         assign prev_seen = b_seen[i-1];
      end

      if (i == BREAK_ENTRIES - 1) begin : g_last
         assign next_addr = '0;
      end else begin : g_mid
         assign next_addr = b_addr[i+1];
      end

      bwt_break_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .key       (req_data.address),
         .prev_addr (prev_addr),
         .next_addr (next_addr),
         .prev_ge   (prev_ge),
         .prev_seen (prev_seen),
         .addr      (b_addr[i]),
         .ge        (b_ge[i]),
         .seen      (b_seen[i]),
         .match     (b_match[i])
      );

      assign b_match_vec[i] = b_match[i];
   end

   assign bp_found = b_seen[BREAK_ENTRIES-1];
   assign bp_hit   = |b_match_vec;

   // Watchpoint chain. An append writes the cell at the current count; a
   // removal shifts down from the first full match and the top cell takes
   // zero, which leaves the freed slot cleared.
   for (genvar i = 0; i < WATCH_ENTRIES; i++) begin : g_watch
      cell_ctl_type    ctl;
      watch_entry_type next_entry;
      logic            prev_seen;

      assign ctl.ins = is_wp_ins && !wp_full && (wcount_ff == WCNT_W'(i));
      assign ctl.rem = is_wp_rem;
      assign ctl.occ = (WCNT_W'(i) < wcount_ff);

      if (i == 0) begin : g_first
         assign prev_seen = 1'b0;
      end else begin : g_inner
         assign prev_seen = w_seen[i-1];
      end

      if (i == WATCH_ENTRIES - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = w_entry[i+1];
      end

      bwt_watch_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (w_key),
         .next_entry (next_entry),
         .prev_seen  (prev_seen),
         .entry      (w_entry[i]),
         .seen       (w_seen[i])
      );
   end

   assign wp_found = w_seen[WATCH_ENTRIES-1];

   // Counts and the response of the transaction taken this cycle.
   always_comb begin
      bcount_in     = bcount_ff;
      wcount_in     = wcount_ff;
      rsp_in.status = ST_OK;
      rsp_in.hit    = 1'b0;
      if (is_bp_ins) begin
         if (bp_full) begin
            rsp_in.status = ST_FULL;
         end else begin
            bcount_in = bcount_ff + BCNT_W'(1);
         end
      end
      if (is_bp_rem) begin
         if (bp_found) begin
            bcount_in = bcount_ff - BCNT_W'(1);
         end else begin
            rsp_in.status = ST_MISSING;
         end
      end
      if (is_wp_ins) begin
         if (wp_full) begin
            rsp_in.status = ST_FULL;
         end else begin
            wcount_in = wcount_ff + WCNT_W'(1);
         end
      end
      if (is_wp_rem) begin
         if (wp_found) begin
            wcount_in = wcount_ff - WCNT_W'(1);
         end else begin
            rsp_in.status = ST_MISSING;
         end
      end
      if (is_check) begin
         rsp_in.hit = bp_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff     <= '0;
         wcount_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         bcount_ff     <= bcount_in;
         wcount_ff     <= wcount_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every taken transaction gets exactly one response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response missing after accepted transaction");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (bcount_ff <= BCNT_W'(BREAK_ENTRIES)) && (wcount_ff <= WCNT_W'(WATCH_ENTRIES)))
      else $error("entry count out of range");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |-> (rsp_data.status == ST_OK))
      else $error("hit reported with error status");

   a_bp_grow: assert property (@(posedge clock) disable iff (reset)
      (is_bp_ins && !bp_full) |=> (bcount_ff == $past(bcount_ff) + BCNT_W'(1)))
      else $error("breakpoint insert did not grow the table");

endmodule
